// ===== rtl/core/dvoc_pkg.sv =====
// Package for the distinct vector occurrence counter: sizes, codes and state type.
package dvoc_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int MAX_ELEMS   = 16;
	localparam int ELEM_BITS   = 16;
	localparam int COUNT_BITS  = 32;

	typedef enum logic [1:0] {
		KIND_ADD   = 2'd0,
		KIND_READ  = 2'd1,
		KIND_CLEAR = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_NEW   = 3'd0,
		ST_MATCH = 3'd1,
		ST_FULL  = 3'd2,
		ST_READ  = 3'd3,
		ST_CLEAR = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SRCH,
		S_RDLD,
		S_EMIT
	} state_t;

endpackage

// ===== rtl/core/dvoc_in_if.sv =====
// Input channel of the distinct vector occurrence counter.
interface dvoc_in_if #(
	parameter int ELEM_BITS = dvoc_pkg::ELEM_BITS,
	parameter int IDX_BITS  = $clog2(dvoc_pkg::MAX_ENTRIES)
);
	logic                        valid;
	logic                        ready;
	logic [1:0]                  kind;
	logic signed [ELEM_BITS-1:0] element;
	logic [IDX_BITS-1:0]         entry_index;

	modport source (output valid, kind, element, entry_index, input ready);
	modport sink   (input valid, kind, element, entry_index, output ready);
endinterface

// ===== rtl/core/dvoc_out_if.sv =====
// Result channel of the distinct vector occurrence counter.
interface dvoc_out_if #(
	parameter int ELEM_BITS  = dvoc_pkg::ELEM_BITS,
	parameter int IDX_BITS   = $clog2(dvoc_pkg::MAX_ENTRIES),
	parameter int TOT_BITS   = $clog2(dvoc_pkg::MAX_ENTRIES + 1),
	parameter int COUNT_BITS = dvoc_pkg::COUNT_BITS
);
	logic                        valid;
	logic                        ready;
	logic [2:0]                  status;
	logic [IDX_BITS-1:0]         slot;
	logic [COUNT_BITS-1:0]       occurrences;
	logic [TOT_BITS-1:0]         distinct_entries;
	logic signed [ELEM_BITS-1:0] stored_element;
	logic                        last;

	modport source (output valid, status, slot, occurrences, distinct_entries,
		stored_element, last, input ready);
	modport sink   (input valid, status, slot, occurrences, distinct_entries,
		stored_element, last, output ready);
endinterface

// ===== rtl/core/distinct_vector_occurrence_counter.sv =====
// Distinct vector occurrence counter: table of distinct vectors with occurrence counts.
//
// Usage: req carries one transaction per element (kind add), per entry read
// (kind read) or per table clear (kind clear); kind 3 is swallowed. rsp carries
// the results, last marking the final result of a request. cfg_we/cfg_wdata
// write vector_length, which the user must do while the block is idle; not enforced.
// Flow: req is taken only in the idle state. An element that does not complete
// a vector gives no result. A completing element searches the table one entry
// per cycle (one row read of the vector memory each cycle), then its result is
// loaded into the output register. A read of a stored entry fetches the row,
// then gives one result per cycle, while the output register is not held, for
// each of the vector_length elements; other reads and a clear give one result.
// Reset: the table is empty, vector_length is MAX_ELEMS, no partial vector.
// The memories are not cleared; entries beyond the fill count never enter a result.
// Stall: results sit in an output register; while it is held the block still
// takes the next request and waits before loading its own result.
module distinct_vector_occurrence_counter #(
	parameter int MAX_ENTRIES = dvoc_pkg::MAX_ENTRIES,
	parameter int MAX_ELEMS   = dvoc_pkg::MAX_ELEMS,
	parameter int ELEM_BITS   = dvoc_pkg::ELEM_BITS,
	parameter int COUNT_BITS  = dvoc_pkg::COUNT_BITS,
	localparam int LW = $clog2(MAX_ELEMS + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [LW-1:0] cfg_wdata,
	dvoc_in_if.sink       req,
	dvoc_out_if.source    rsp
);

	localparam int IB = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int EB = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;

	typedef logic [MAX_ELEMS-1:0][ELEM_BITS-1:0] row_t;

	dvoc_pkg::state_t  state_q, state_d;
	logic [LW-1:0]     vlen_q, len_eff;
	logic [EB-1:0]     pos_q;
	logic [LW-1:0]     pos1;
	logic [CW-1:0]     tot_q;
	logic [CW-1:0]     e_q;
	logic [IB-1:0]     e_prev_q;
	logic              chk_q;
	logic [EB-1:0]     el_q;
	logic [ELEM_BITS-1:0] pend_q [MAX_ELEMS];

	row_t              vec_mem [MAX_ENTRIES];
	logic [COUNT_BITS-1:0] cnt_mem [MAX_ENTRIES];
	row_t              rd_row_q, row_q, row_new;
	logic [COUNT_BITS-1:0] rd_cnt_q, cnt_inc, cnt_wd;

	dvoc_pkg::status_t res_status_q, o_status_q;
	logic [IB-1:0]     res_slot_q, o_slot_q;
	logic [COUNT_BITS-1:0] res_occ_q, o_occ_q;
	logic              res_multi_q;
	logic [CW-1:0]     o_tot_q;
	logic [ELEM_BITS-1:0] o_elem_q;
	logic              o_last_q, o_valid_q;

	logic              req_rdy, acc, add_done, rd_hit, full, match, out_free;
	logic              issue, hit, miss, vec_we, cnt_we, emit_ld, emit_last;
	logic [IB-1:0]     rd_addr, wa;

	always_comb begin
		if (vlen_q == '0)
			len_eff = LW'(1);
		else if (vlen_q > LW'(MAX_ELEMS))
			len_eff = LW'(MAX_ELEMS);
		else
			len_eff = vlen_q;
	end

	assign pos1     = LW'(pos_q) + LW'(1);
	assign add_done = (pos1 >= len_eff);
	assign rd_hit   = (CW'(req.entry_index) < tot_q);
	assign full     = (tot_q == CW'(MAX_ENTRIES));
	assign out_free = !o_valid_q || rsp.ready;
	assign acc      = req.valid && req_rdy;
	assign cnt_inc  = (rd_cnt_q == '1) ? rd_cnt_q : rd_cnt_q + COUNT_BITS'(1);

	// row compare against the pending vector, positions beyond the length ignored
	always_comb begin
		match = 1'b1;
		for (int i = 0; i < MAX_ELEMS; i++) begin
			if (LW'(i) < len_eff) begin
				row_new[i] = pend_q[i];
				if (rd_row_q[i] != pend_q[i])
					match = 1'b0;
			end else begin
				row_new[i] = '0;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dvoc_pkg::S_IDLE: begin
				if (acc) begin
					case (req.kind)
						dvoc_pkg::KIND_ADD: begin
							if (add_done)
								state_d = dvoc_pkg::S_SRCH;
						end
						dvoc_pkg::KIND_READ: begin
							state_d = rd_hit ? dvoc_pkg::S_RDLD : dvoc_pkg::S_EMIT;
						end
						dvoc_pkg::KIND_CLEAR: state_d = dvoc_pkg::S_EMIT;
						default: state_d = dvoc_pkg::S_IDLE;
					endcase
				end
			end
			dvoc_pkg::S_SRCH: begin
				if (hit || miss)
					state_d = dvoc_pkg::S_EMIT;
			end
			dvoc_pkg::S_RDLD: state_d = dvoc_pkg::S_EMIT;
			dvoc_pkg::S_EMIT: begin
				if (emit_ld && emit_last)
					state_d = dvoc_pkg::S_IDLE;
			end
			default: state_d = dvoc_pkg::S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		req_rdy   = 1'b0;
		issue     = 1'b0;
		hit       = 1'b0;
		miss      = 1'b0;
		vec_we    = 1'b0;
		cnt_we    = 1'b0;
		emit_ld   = 1'b0;
		wa        = e_prev_q;
		cnt_wd    = cnt_inc;
		rd_addr   = e_q[IB-1:0];
		emit_last = !res_multi_q || (LW'(el_q) + LW'(1) == len_eff);
		case (state_q)
			dvoc_pkg::S_IDLE: begin
				req_rdy = 1'b1;
				rd_addr = req.entry_index;
			end
			dvoc_pkg::S_SRCH: begin
				issue = (e_q < tot_q);
				hit   = chk_q && match;
				miss  = !hit && !issue;
				if (hit) begin
					cnt_we = 1'b1;
				end else if (miss && !full) begin
					vec_we = 1'b1;
					cnt_we = 1'b1;
					wa     = tot_q[IB-1:0];
					cnt_wd = COUNT_BITS'(1);
				end
			end
			dvoc_pkg::S_EMIT: emit_ld = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (vec_we)
			vec_mem[wa] <= row_new;
		if (cnt_we)
			cnt_mem[wa] <= cnt_wd;
		rd_row_q <= vec_mem[rd_addr];
		rd_cnt_q <= cnt_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= dvoc_pkg::S_IDLE;
			vlen_q    <= LW'(MAX_ELEMS);
			pos_q     <= '0;
			tot_q     <= '0;
			e_q       <= '0;
			chk_q     <= 1'b0;
			el_q      <= '0;
			o_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we)
				vlen_q <= cfg_wdata;
			if (acc && req.kind == dvoc_pkg::KIND_ADD)
				pos_q <= add_done ? '0 : pos1[EB-1:0];
			if (acc && req.kind == dvoc_pkg::KIND_CLEAR)
				tot_q <= '0;
			else if (vec_we)
				tot_q <= tot_q + CW'(1);
			if (acc) begin
				e_q   <= '0;
				chk_q <= 1'b0;
				el_q  <= '0;
			end
			if (state_q == dvoc_pkg::S_SRCH) begin
				chk_q <= issue;
				if (issue)
					e_q <= e_q + CW'(1);
			end
			if (emit_ld && !emit_last)
				el_q <= el_q + EB'(1);
			if (emit_ld)
				o_valid_q <= 1'b1;
			else if (rsp.ready)
				o_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && req.kind == dvoc_pkg::KIND_ADD)
			pend_q[pos_q] <= req.element;
		e_prev_q <= e_q[IB-1:0];
		if (acc && req.kind == dvoc_pkg::KIND_READ) begin
			res_status_q <= dvoc_pkg::ST_READ;
			res_slot_q   <= req.entry_index;
			res_occ_q    <= '0;
			res_multi_q  <= rd_hit;
		end else if (acc && req.kind == dvoc_pkg::KIND_CLEAR) begin
			res_status_q <= dvoc_pkg::ST_CLEAR;
			res_slot_q   <= '0;
			res_occ_q    <= '0;
			res_multi_q  <= 1'b0;
		end else if (hit) begin
			res_status_q <= dvoc_pkg::ST_MATCH;
			res_slot_q   <= e_prev_q;
			res_occ_q    <= cnt_inc;
			res_multi_q  <= 1'b0;
		end else if (miss) begin
			res_status_q <= full ? dvoc_pkg::ST_FULL : dvoc_pkg::ST_NEW;
			res_slot_q   <= full ? '0 : tot_q[IB-1:0];
			res_occ_q    <= full ? '0 : COUNT_BITS'(1);
			res_multi_q  <= 1'b0;
		end else if (state_q == dvoc_pkg::S_RDLD) begin
			row_q     <= rd_row_q;
			res_occ_q <= rd_cnt_q;
		end
		if (emit_ld) begin
			o_status_q <= res_status_q;
			o_slot_q   <= res_slot_q;
			o_occ_q    <= res_occ_q;
			o_tot_q    <= tot_q;
			o_elem_q   <= res_multi_q ? row_q[el_q] : '0;
			o_last_q   <= emit_last;
		end
	end

	assign req.ready            = req_rdy;
	assign rsp.valid            = o_valid_q;
	assign rsp.status           = o_status_q;
	assign rsp.slot             = o_slot_q;
	assign rsp.occurrences      = o_occ_q;
	assign rsp.distinct_entries = o_tot_q;
	assign rsp.stored_element   = o_elem_q;
	assign rsp.last             = o_last_q;

	a_tot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tot_q <= CW'(MAX_ENTRIES))
		else $error("entry count beyond table size");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit_ld |-> (!o_valid_q || rsp.ready))
		else $error("result loaded over a held transaction");

	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		vec_we |-> (tot_q < CW'(MAX_ENTRIES)))
		else $error("append into a full table");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && req.kind == dvoc_pkg::KIND_CLEAR) |=> (tot_q == '0))
		else $error("table not empty after clear");

	a_chk_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dvoc_pkg::S_SRCH && chk_q) |-> (e_q != '0))
		else $error("compare pending without an issued row");

endmodule
